// ===== hw/rtl/kcal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_pkg
// Shared types, constants and the key scan function of the keypad code lock.
// ----------------------------------------------------------------------------
package kcal_pkg;

    // default sizes
    localparam int CODE_LENGTH_DEF = 4;
    localparam int KEY_ROWS        = 4;
    localparam int KEY_COLS        = 4;
    localparam int MAP_W           = 16;
    localparam int KEY_W           = 4;
    localparam int CODE_REGS       = 4;
    localparam int SCAN_KEYS       = (KEY_ROWS * KEY_COLS < MAP_W) ? KEY_ROWS * KEY_COLS : MAP_W;

    // keypad legends by row-major index
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;
    localparam logic [KEY_W-1:0] KEY_ZERO = 4'd13;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

    // configuration register indexes
    localparam logic [2:0] REG_CODE_KEY_0      = 3'd0;
    localparam logic [2:0] REG_CODE_KEY_1      = 3'd1;
    localparam logic [2:0] REG_CODE_KEY_2      = 3'd2;
    localparam logic [2:0] REG_CODE_KEY_3      = 3'd3;
    localparam logic [2:0] REG_MAX_WRONG       = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE_TICKS  = 3'd5;
    localparam logic [2:0] REG_HASH_TO_CLEAR   = 3'd6;

    // register reset values
    localparam logic [3:0] MAX_WRONG_RST  = 4'd5;
    localparam logic [7:0] DEBOUNCE_RST   = 8'd4;
    localparam logic [1:0] HASH_CLEAR_RST = 2'd2;
    localparam logic [CODE_REGS-1:0][KEY_W-1:0] CODE_KEY_RST = {4'd5, 4'd13, 4'd9, 4'd0};

    // configuration register set
    typedef struct packed {
        logic [CODE_REGS-1:0][KEY_W-1:0] code_key;
        logic [3:0]                      max_wrong;
        logic [7:0]                      debounce_ticks;
        logic [1:0]                      hash_clear;
    } cfg_t;

    // key release seen by the scanner this tick
    typedef struct packed {
        logic             released;
        logic [KEY_W-1:0] key;
    } release_t;

    // indicator flags after this tick
    typedef struct packed {
        logic alarm;
        logic warning;
        logic lockout;
    } status_t;

    // first closed key in row-major order, found flag in the top bit
    function automatic logic [KEY_W:0] first_key(input logic [MAP_W-1:0] map);
        logic [KEY_W:0] res;
        res = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (i < SCAN_KEYS && map[i])
            begin
                res = {1'b1, KEY_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/kcal_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_scan
// Scan, debounce and hold machine; reports a held key once on its release.
// ----------------------------------------------------------------------------
module kcal_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [15:0]          key_down_map,
    input  logic [7:0]           debounce_ticks,
    output kcal_pkg::release_t   rel
);
    import kcal_pkg::*;

    localparam logic [1:0] ST_SCAN     = 2'd0;
    localparam logic [1:0] ST_DEBOUNCE = 2'd1;
    localparam logic [1:0] ST_HOLD     = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [8:0]       count_reg, count_next;
    logic [KEY_W-1:0] held_reg, held_next;
    logic [KEY_W:0]   scan;
    logic             found;
    logic [KEY_W-1:0] key;

    assign scan  = first_key(key_down_map);
    assign found = scan[KEY_W];
    assign key   = scan[KEY_W-1:0];

    // next state and release report
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        rel.released = 1'b0;
        rel.key      = '0;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (found)
                begin
                    held_next  = key;
                    count_next = '0;
                    state_next = ST_DEBOUNCE;
                end
            end
            ST_DEBOUNCE:
            begin
                if (count_reg >= {1'b0, debounce_ticks})
                begin
                    state_next = (found && key == held_reg) ? ST_HOLD : ST_SCAN;
                end
                if (count_reg != 9'h1FF)
                begin
                    count_next = count_reg + 9'd1;
                end
            end
            ST_HOLD:
            begin
                if (!found || key != held_reg)
                begin
                    if (!found)
                    begin
                        rel.released = 1'b1;
                        rel.key      = held_reg;
                    end
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    // state registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
            count_reg <= '0;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hw/rtl/kcal_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcal_entry
// Digit ring, code compare, wrong-code and hash counters, alarm flags.
// ----------------------------------------------------------------------------
module kcal_entry #(
    parameter int CODE_LENGTH = kcal_pkg::CODE_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  kcal_pkg::release_t   rel,
    input  logic                 alarm_trigger,
    input  kcal_pkg::cfg_t       cfg,
    output kcal_pkg::status_t    status_next
);
    import kcal_pkg::*;

    localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_LENGTH - 1);

    logic [KEY_W-1:0] ring_reg [CODE_LENGTH];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       wrong_reg, wrong_next;
    logic [1:0]       hash_reg, hash_next;
    logic [1:0]       hash_inc;
    logic             alarm_reg, alarm_next;
    logic             warn_reg, warn_next;
    logic             lock_reg, lock_next;
    logic             code_ok;
    logic             store;

    // compare ring with the code; positions past the registers expect key 0
    always_comb
    begin
        code_ok = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (i < CODE_REGS)
            begin
                if (ring_reg[i] != cfg.code_key[i % CODE_REGS])
                begin
                    code_ok = 1'b0;
                end
            end
            else if (ring_reg[i] != '0)
            begin
                code_ok = 1'b0;
            end
        end
    end

    assign hash_inc = (hash_reg != 2'd3) ? hash_reg + 2'd1 : hash_reg;

    // per-tick update of counters and flags
    always_comb
    begin
        pos_next   = pos_reg;
        wrong_next = wrong_reg;
        hash_next  = hash_reg;
        alarm_next = alarm_reg;
        warn_next  = warn_reg;
        lock_next  = lock_reg;
        store      = 1'b0;
        if (wrong_reg < cfg.max_wrong)
        begin
            if (rel.released && rel.key != KEY_HASH && rel.key != KEY_STAR)
            begin
                store    = 1'b1;
                pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
            end
            if (rel.released && rel.key == KEY_HASH)
            begin
                if (warn_reg)
                begin
                    hash_next = hash_inc;
                    if (hash_inc >= cfg.hash_clear)
                    begin
                        warn_next = 1'b0;
                        hash_next = '0;
                        pos_next  = '0;
                    end
                end
                else if (alarm_reg)
                begin
                    if (code_ok)
                    begin
                        alarm_next = 1'b0;
                        wrong_next = '0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        warn_next = 1'b1;
                        if (wrong_reg != 4'd15)
                        begin
                            wrong_next = wrong_reg + 4'd1;
                        end
                    end
                end
            end
        end
        else
        begin
            lock_next = 1'b1;
        end
        if (alarm_trigger)
        begin
            alarm_next = 1'b1;
        end
    end

    assign status_next.alarm   = alarm_next;
    assign status_next.warning = warn_next;
    assign status_next.lockout = lock_next;

    // control and ring registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            wrong_reg <= '0;
            hash_reg  <= '0;
            alarm_reg <= 1'b0;
            warn_reg  <= 1'b0;
            lock_reg  <= 1'b0;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                ring_reg[i] <= KEY_ZERO;
            end
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            wrong_reg <= wrong_next;
            hash_reg  <= hash_next;
            alarm_reg <= alarm_next;
            warn_reg  <= warn_next;
            lock_reg  <= lock_next;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                if (store && pos_reg == POS_W'(i))
                begin
                    ring_reg[i] <= rel.key;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/keypad_code_alarm_lock_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_alarm_lock_top
// Keypad code lock for an alarm, one 10 ms tick per input item.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid/s_tready  | s_tdata: key map, trigger
//   m_      | out       | m_tvalid/m_tready  | m_tdata: flags, released key
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while m_tready holds high; each item passes
// from the input register through the scan and entry logic into the result
// register, which drives m_. While a result waits on m_tready an empty input
// register still takes one item, after which s_tready drops until m_tready
// returns. Reset puts the lock in its idle state with the default code; no
// clearing pass. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module keypad_code_alarm_lock_top #(
    parameter int CODE_LENGTH = kcal_pkg::CODE_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] key_down_map, [16] alarm_trigger
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] alarm_on, [1] code_warning, [2] lockout,
                                    // [3] key_released, [7:4] released_key,
                                    // [8] log_dump_request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import kcal_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [15:0] map_reg;
    logic        trig_reg;
    logic        out_valid_reg;
    logic [15:0] out_reg, out_next;
    logic        advance;
    release_t    rel;
    status_t     status_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_key       <= CODE_KEY_RST;
            cfg_reg.max_wrong      <= MAX_WRONG_RST;
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.hash_clear     <= HASH_CLEAR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CODE_KEY_0, REG_CODE_KEY_1, REG_CODE_KEY_2, REG_CODE_KEY_3:
                begin
                    if ({29'd0, cfg_index} < 32'(CODE_LENGTH))
                    begin
                        cfg_reg.code_key[cfg_index[1:0]] <= cfg_data[3:0];
                    end
                end
                REG_MAX_WRONG:      cfg_reg.max_wrong      <= cfg_data[3:0];
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data;
                REG_HASH_TO_CLEAR:  cfg_reg.hash_clear     <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            map_reg  <= s_tdata[15:0];
            trig_reg <= s_tdata[16];
        end
    end

    kcal_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .key_down_map   (map_reg),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .rel            (rel)
    );

    kcal_entry #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_entry (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .rel           (rel),
        .alarm_trigger (trig_reg),
        .cfg           (cfg_reg),
        .status_next   (status_next)
    );

    // result packing
    always_comb
    begin
        out_next      = '0;
        out_next[0]   = status_next.alarm;
        out_next[1]   = status_next.warning;
        out_next[2]   = status_next.lockout;
        out_next[3]   = rel.released;
        out_next[7:4] = rel.key;
        out_next[8]   = rel.released && rel.key == KEY_STAR;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // no key index without a release
    a_key_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[7:4] == 4'd0)
        else $error("released key set without a release");

    // dump request only on a star release
    a_dump_is_star: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[3] && m_tdata[7:4] == KEY_STAR)
        else $error("dump request without star release");

    // lockout never drops once shown
    a_lockout_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(m_tdata[2]) |-> m_tdata[2])
        else $error("lockout cleared");

    // an empty input stage always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock. Ticks go in on the s_ stream
// and every tick gives one panel item on the m_ stream; a behavioural copy of
// the scan, debounce, code entry and lockout logic predicts each panel item
// and the bench compares it field by field. A short table of ticks comes
// first, then random key presses, code attempts and noise under several
// register settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    import kcal_pkg::*;

    // index past the last register, writes to it are dropped
    localparam logic [2:0] REG_NONE = 3'd7;

    // keypad machine states
    typedef enum logic [1:0] {SC_SCAN, SC_DEBOUNCE, SC_HOLD} scan_st_t;

    // one panel item, as it leaves on m_tdata
    typedef struct packed {
        logic       alarm;
        logic       warning;
        logic       lockout;
        logic       released;
        logic [3:0] key;
        logic       dump;
    } panel_t;

    // one row of the opening table
    typedef struct packed {
        logic [15:0] map;
        logic        trig;
        logic        fixed_en;
        panel_t      fixed;
    } tick_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;      // [15:0] key_down_map, [16] alarm_trigger
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [0] alarm_on, [1] code_warning, [2] lockout,
                               // [3] key_released, [7:4] released_key,
                               // [8] log_dump_request
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // register copy
    logic [3:0][3:0] code_key   = CODE_KEY_RST;
    logic [3:0]      max_wrong  = MAX_WRONG_RST;
    logic [7:0]      deb_ticks  = DEBOUNCE_RST;
    logic [1:0]      hash_clear = HASH_CLEAR_RST;

    // lock state copy
    scan_st_t        scan_st   = SC_SCAN;
    logic [8:0]      bounce_cnt = '0;
    logic [3:0]      held_key  = '0;
    logic [3:0][3:0] entered   = {4{KEY_ZERO}};
    logic [1:0]      entry_pos = '0;
    logic [3:0]      wrong_cnt = '0;
    logic [1:0]      hash_cnt  = '0;
    logic            alarm_q   = 1'b0;
    logic            warn_q    = 1'b0;
    logic            lock_q    = 1'b0;

    panel_t    due_panels[$];
    panel_t    head_panel;
    tick_row_t tick_rows [0:24];
    int        err_count = 0;
    int        issued    = 0;
    bit        idle_en   = 1'b1;
    bit        stall_en  = 1'b1;
    bit        calm      = 1'b0;

    keypad_code_alarm_lock_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // lowest closed key, found flag on top
    function automatic logic [4:0] lowest_closed(input logic [15:0] map);
        for (int i = 0; i < 16; i++)
        begin
            if (map[i])
                return {1'b1, 4'(i)};
        end
        return 5'd0;
    endfunction

    // one tick of the lock: keypad machine, released key, then trigger
    function automatic panel_t advance_lock(input logic [15:0] map, input logic trig);
        panel_t     p;
        logic [4:0] fk;
        p  = '0;
        fk = lowest_closed(map);
        case (scan_st)
            SC_SCAN:
            begin
                if (fk[4])
                begin
                    held_key   = fk[3:0];
                    bounce_cnt = '0;
                    scan_st    = SC_DEBOUNCE;
                end
            end
            SC_DEBOUNCE:
            begin
                if (bounce_cnt >= {1'b0, deb_ticks})
                    scan_st = (fk[4] && fk[3:0] == held_key) ? SC_HOLD : SC_SCAN;
                if (bounce_cnt != 9'd511)
                    bounce_cnt = bounce_cnt + 9'd1;
            end
            SC_HOLD:
            begin
                if (!fk[4] || fk[3:0] != held_key)
                begin
                    if (!fk[4])
                    begin
                        p.released = 1'b1;
                        p.key      = held_key;
                    end
                    scan_st = SC_SCAN;
                end
            end
            default: scan_st = SC_SCAN;
        endcase
        p.dump = p.released && p.key == KEY_STAR;

        // entry is frozen once the wrong count reaches the limit
        if (wrong_cnt < max_wrong)
        begin
            if (p.released && p.key != KEY_HASH && p.key != KEY_STAR)
            begin
                entered[entry_pos] = p.key;
                entry_pos          = entry_pos + 2'd1;  // ring of four wraps by width
            end
            if (p.released && p.key == KEY_HASH)
            begin
                if (warn_q)
                begin
                    if (hash_cnt != 2'd3)
                        hash_cnt = hash_cnt + 2'd1;
                    if (hash_cnt >= hash_clear)
                    begin
                        warn_q    = 1'b0;
                        hash_cnt  = '0;
                        entry_pos = '0;
                    end
                end
                else if (alarm_q)
                begin
                    if (entered == code_key)
                    begin
                        alarm_q   = 1'b0;
                        wrong_cnt = '0;
                        entry_pos = '0;
                    end
                    else
                    begin
                        warn_q = 1'b1;
                        if (wrong_cnt != 4'd15)
                            wrong_cnt = wrong_cnt + 4'd1;
                    end
                end
            end
        end
        else
        begin
            lock_q = 1'b1;
        end

        if (!alarm_q && trig)
            alarm_q = 1'b1;
        p.alarm   = alarm_q;
        p.warning = warn_q;
        p.lockout = lock_q;
        return p;
    endfunction

    // register write as the lock sees it
    function automatic void apply_reg(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            REG_CODE_KEY_0, REG_CODE_KEY_1, REG_CODE_KEY_2, REG_CODE_KEY_3:
                code_key[idx[1:0]] = val[3:0];
            REG_MAX_WRONG:      max_wrong  = val[3:0];
            REG_DEBOUNCE_TICKS: deb_ticks  = val;
            REG_HASH_TO_CLEAR:  hash_clear = val[1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // valid is left high, the caller lowers it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic load_config(input logic [7:0] k0, input logic [7:0] k1,
                               input logic [7:0] k2, input logic [7:0] k3,
                               input logic [7:0] mw, input logic [7:0] db,
                               input logic [7:0] hc);
        write_reg(REG_CODE_KEY_0, k0);
        write_reg(REG_CODE_KEY_1, k1);
        write_reg(REG_CODE_KEY_2, k2);
        write_reg(REG_CODE_KEY_3, k3);
        write_reg(REG_MAX_WRONG, mw);
        write_reg(REG_DEBOUNCE_TICKS, db);
        write_reg(REG_HASH_TO_CLEAR, hc);
        write_reg(REG_NONE, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // send one tick, queue the panel item it should give
    task automatic send_tick(input logic [15:0] map, input logic trig,
                             input logic fixed_en, input panel_t fixed);
        panel_t p;
        if (idle_en && !calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tdata  <= {7'd0, trig, map};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        p = advance_lock(map, trig);
        due_panels.push_back(fixed_en ? fixed : p);
        issued++;
    endtask

    // stop sending and wait for every panel item to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_panels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int full_len();
        return int'(deb_ticks) + 2 + $urandom_range(0, 2);
    endfunction

    function automatic logic rare_trig();
        return $urandom_range(0, 15) == 0;
    endfunction

    // hold a key, with random higher keys that leave it first, then let go
    task automatic press(input logic [3:0] key, input int hold_len);
        logic [15:0] above;
        for (int i = 0; i < hold_len; i++)
        begin
            above = ($urandom_range(0, 1) == 1) ?
                    16'($urandom) & ~16'((32'd2 << key) - 32'd1) : 16'd0;
            send_tick(16'(32'd1 << key) | above, rare_trig(), 1'b0, '0);
        end
        repeat ($urandom_range(1, 2))
            send_tick(16'd0, rare_trig(), 1'b0, '0);
    endtask

    function automatic logic [3:0] digit_key();
        logic [3:0] k;
        do k = 4'($urandom_range(0, 15)); while (k == KEY_STAR || k == KEY_HASH);
        return k;
    endfunction

    // an optional trigger tick, four digits, either the set code or random, then hash
    task automatic try_code();
        logic exact;
        exact = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1)
            send_tick(16'd0, 1'b1, 1'b0, '0);
        for (int i = 0; i < 4; i++)
            press(exact ? code_key[i] : digit_key(), full_len());
        press(KEY_HASH, full_len());
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        int pick;
        stop_at = issued + n;
        while (issued < stop_at)
        begin
            pick = $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            if (pick == 0)
                repeat ($urandom_range(1, 4))
                    send_tick(16'($urandom), 1'($urandom), 1'b0, '0);
            else if (pick == 1)
                press(4'($urandom), $urandom_range(1, int'(deb_ticks) + 1));
            else if (pick <= 3)
                press(4'($urandom), full_len());
            else if (pick <= 8)
                try_code();
            else
                repeat ($urandom_range(1, 3))
                    press(KEY_HASH, full_len());
        end
        calm = 1'b0;
    endtask

    // result side: random ready bursts
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_en && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // compare each panel item with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_panels.size() == 0)
            begin
                report_mismatch("panel item with none due", m_tdata, 16'd0);
            end
            else
            begin
                head_panel = due_panels.pop_front();
                if (m_tdata[0] != head_panel.alarm)
                    report_mismatch("alarm_on", 16'(m_tdata[0]),
                                    16'(head_panel.alarm));
                if (m_tdata[1] != head_panel.warning)
                    report_mismatch("code_warning", 16'(m_tdata[1]),
                                    16'(head_panel.warning));
                if (m_tdata[2] != head_panel.lockout)
                    report_mismatch("lockout", 16'(m_tdata[2]),
                                    16'(head_panel.lockout));
                if (m_tdata[3] != head_panel.released)
                    report_mismatch("key_released", 16'(m_tdata[3]),
                                    16'(head_panel.released));
                if (m_tdata[7:4] != head_panel.key)
                    report_mismatch("released_key", 16'(m_tdata[7:4]),
                                    16'(head_panel.key));
                if (m_tdata[8] != head_panel.dump)
                    report_mismatch("log_dump_request", 16'(m_tdata[8]),
                                    16'(head_panel.dump));
                if (m_tdata[15:9] != '0)
                    report_mismatch("padding", 16'(m_tdata[15:9]), 16'd0);
            end
        end
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // opening table, debounce off, reset code
        // fixed item fields: alarm, warning, lockout, released, key, dump
        tick_rows = '{
            '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0}},
            '{16'hFFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0}},
            '{16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0}},
            '{16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
            '{16'h0200, 1'b0, 1'b0, '0},
            '{16'h0600, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, '0},
            '{16'h2000, 1'b0, 1'b0, '0},
            '{16'hE000, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, '0},
            '{16'h0020, 1'b0, 1'b0, '0},
            '{16'h0020, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, '0},
            '{16'h4000, 1'b0, 1'b0, '0},
            '{16'h4000, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, '0},
            '{16'h1000, 1'b0, 1'b0, '0},
            '{16'h1000, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b1, 1'b0, '0},
            '{16'h8000, 1'b0, 1'b0, '0},
            '{16'h0008, 1'b0, 1'b0, '0},
            '{16'h0008, 1'b0, 1'b0, '0},
            '{16'h0008, 1'b0, 1'b0, '0},
            '{16'h0009, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_DEBOUNCE_TICKS, 8'd0);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 25; i++)
            send_tick(tick_rows[i].map, tick_rows[i].trig,
                      tick_rows[i].fixed_en, tick_rows[i].fixed);

        // short limits, with a full drain part way through
        settle();
        load_config(8'(digit_key()), 8'(digit_key()), 8'(digit_key()), 8'(digit_key()),
                    8'd3, 8'd1, 8'd1);
        run_phase(25);
        settle();
        run_phase(25);

        // top code key, highest limits
        settle();
        stall_en = 1'($urandom_range(0, 1));
        load_config(8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd0, 8'd3);
        run_phase(40);

        // zero limits: immediate lockout, so entry is frozen and no hash is counted
        settle();
        stall_en = 1'b1;
        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0);
        run_phase(25);

        // longest debounce: one full press and one cut short
        settle();
        load_config(8'(digit_key()), 8'(digit_key()), 8'(digit_key()), 8'(digit_key()),
                    8'd15, 8'd255, 8'd1);
        press(code_key[0], full_len());
        press(4'($urandom), $urandom_range(1, 20));

        // random register bytes, upper bits dropped by the lock
        settle();
        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), {6'($urandom), 2'($urandom)} & 8'h03, 8'($urandom));
        run_phase(35);
        idle_en  = 1'b0;
        stall_en = 1'b0;
        run_phase(25);

        // drain and let the pipeline run empty
        s_tvalid <= 1'b0;
        while (due_panels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
